// ===== rtl/caq_pkg.sv =====
// Package for the cycle alarm queue: field widths, codes, entry and chain-op types.
// No dependencies; used by every module of the block.
package caq_pkg;

  localparam int unsigned TRIG_W         = 63;
  localparam int unsigned PAY_W          = 64;
  localparam int unsigned FIRE_LIMIT     = 16;
  localparam int unsigned FIRE_W         = $clog2(FIRE_LIMIT + 1);
  localparam int unsigned DEF_MAX_ALARMS = 16;
  localparam int unsigned IN_DATA_W      = 128;
  localparam int unsigned OUT_DATA_W     = 128;

  localparam logic [TRIG_W-1:0] TRIG_MAX = {TRIG_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ADD_ABS = 2'd0,
    CMD_ADD_REL = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_FIRED  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_OUT,
    ST_SCAN,
    ST_FIRE
  } state_e;

  typedef struct packed {
    logic [TRIG_W-1:0] trig;
    logic [PAY_W-1:0]  pay;
  } entry_t;

  // One command broadcast to every cell of the chain.
  typedef struct packed {
    logic   shift;   // every cell takes its upper neighbor
    logic   write;   // the addressed cell loads data instead
    entry_t data;
  } chain_op_t;

endpackage

// ===== rtl/caq_cell.sv =====
// One alarm slot of the chain: holds a trigger and a payload.
// Depends on caq_pkg for entry_t and chain_op_t.
module caq_cell (
  input  logic               clk_i,
  input  caq_pkg::chain_op_t op_i,
  input  logic               hit_i,
  input  caq_pkg::entry_t    nbr_i,
  output caq_pkg::entry_t    ent_o
);

  caq_pkg::entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (op_i.write && hit_i) begin
      ent_d = op_i.data;
    end else if (op_i.shift) begin
      ent_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// ===== rtl/caq_ctrl.sv =====
// Sequencer of the alarm queue: stream ports, cycle counter, fill count, minimum
// tracking and the output register. Depends on caq_pkg; drives the cell chain.
module caq_ctrl #(
  parameter int unsigned MAX_ALARMS = caq_pkg::DEF_MAX_ALARMS,
  localparam int unsigned IDX_W = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_ALARMS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [1:0]                     s_axis_tuser,  // cmd
  input  logic [caq_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // when_cycle, payload
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [1:0]                     m_axis_tuser,  // kind
  output logic                           m_axis_tlast,  // last
  output logic [caq_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // fired_payload, next_due
  input  caq_pkg::entry_t                head_i,
  output caq_pkg::chain_op_t             op_o,
  output logic [IDX_W-1:0]               wr_pos_o
);

  localparam int unsigned TW = caq_pkg::TRIG_W;
  localparam int unsigned PW = caq_pkg::PAY_W;
  localparam int unsigned FW = caq_pkg::FIRE_W;

  caq_pkg::state_e state_q, state_d;

  logic [TW-1:0]    cycle_q, cycle_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [FW-1:0]    nf_q, nf_d;
  logic [FW-1:0]    fired_q, fired_d;
  logic [TW-1:0]    min_q, min_d;
  logic [TW-1:0]    kmin_q, kmin_d;
  caq_pkg::kind_e   rsp_kind_q, rsp_kind_d;
  logic [TW-1:0]    rsp_due_q, rsp_due_d;
  logic             ov_q, ov_d;
  caq_pkg::kind_e   okind_q, okind_d;
  logic [PW-1:0]    opay_q, opay_d;
  logic [TW-1:0]    odue_q, odue_d;
  logic             olast_q, olast_d;

  logic             in_acc;
  logic [TW-1:0]    in_when;
  logic [PW-1:0]    in_pay;
  logic [TW:0]      rel_sum;
  logic [TW-1:0]    ins_trig;
  logic [TW-1:0]    ins_min;
  logic             head_due;
  logic             fire_sel;
  logic             ofree;
  logic             last_step;
  logic             step_go;
  logic             full;
  logic [CNT_W-1:0] cnt_m1;
  logic [TW-1:0]    cyc_inc;

  assign s_axis_tready = (state_q == caq_pkg::ST_IDLE);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_when   = s_axis_tdata[TW-1:0];
  assign in_pay    = s_axis_tdata[TW+PW-1:TW];
  assign rel_sum   = {1'b0, cycle_q} + {1'b0, in_when};
  assign ins_trig  = (caq_pkg::cmd_e'(s_axis_tuser) == caq_pkg::CMD_ADD_REL)
                     ? (rel_sum[TW] ? caq_pkg::TRIG_MAX : rel_sum[TW-1:0])
                     : in_when;
  assign ins_min   = (ins_trig < min_q) ? ins_trig : min_q;
  assign head_due  = (head_i.trig <= cycle_q);
  assign fire_sel  = head_due && (fired_q < FW'(caq_pkg::FIRE_LIMIT));
  assign ofree     = !ov_q || m_axis_tready;
  assign last_step = (rem_q == CNT_W'(1));
  assign step_go   = !fire_sel || ofree;
  assign full      = (count_q == CNT_W'(MAX_ALARMS));
  assign cnt_m1    = count_q - CNT_W'(1);
  assign cyc_inc   = (cycle_q == caq_pkg::TRIG_MAX) ? cycle_q : cycle_q + TW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      caq_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (caq_pkg::cmd_e'(s_axis_tuser))
            caq_pkg::CMD_ADD_ABS,
            caq_pkg::CMD_ADD_REL: state_d = caq_pkg::ST_INS_OUT;
            caq_pkg::CMD_TICK: begin
              if (count_q != '0) state_d = caq_pkg::ST_SCAN;
            end
            default: state_d = caq_pkg::ST_IDLE;
          endcase
        end
      end
      caq_pkg::ST_INS_OUT: begin
        if (ofree) state_d = caq_pkg::ST_IDLE;
      end
      caq_pkg::ST_SCAN: begin
        if (last_step) state_d = (nf_d == '0) ? caq_pkg::ST_IDLE : caq_pkg::ST_FIRE;
      end
      caq_pkg::ST_FIRE: begin
        if (step_go && last_step) state_d = caq_pkg::ST_IDLE;
      end
      default: state_d = caq_pkg::ST_IDLE;
    endcase
  end

  // datapath and chain control
  always_comb begin
    cycle_d    = cycle_q;
    count_d    = count_q;
    rem_d      = rem_q;
    nf_d       = nf_q;
    fired_d    = fired_q;
    min_d      = min_q;
    kmin_d     = kmin_q;
    rsp_kind_d = rsp_kind_q;
    rsp_due_d  = rsp_due_q;
    ov_d       = ov_q && !m_axis_tready;
    okind_d    = okind_q;
    opay_d     = opay_q;
    odue_d     = odue_q;
    olast_d    = olast_q;
    op_o       = '0;
    op_o.data  = head_i;
    wr_pos_o   = cnt_m1[IDX_W-1:0];

    unique case (state_q)
      caq_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (caq_pkg::cmd_e'(s_axis_tuser))
            caq_pkg::CMD_ADD_ABS,
            caq_pkg::CMD_ADD_REL: begin
              if (!full) begin
                op_o.write     = 1'b1;
                op_o.data.trig = ins_trig;
                op_o.data.pay  = in_pay;
                wr_pos_o       = count_q[IDX_W-1:0];
                count_d        = count_q + CNT_W'(1);
                min_d          = ins_min;
                rsp_kind_d     = caq_pkg::KIND_ACCEPT;
                rsp_due_d      = ins_min;
              end else begin
                rsp_kind_d = caq_pkg::KIND_REJECT;
                rsp_due_d  = min_q;
              end
            end
            caq_pkg::CMD_TICK: begin
              if (count_q == '0) begin
                cycle_d = cyc_inc;
              end else begin
                rem_d  = count_q;
                nf_d   = '0;
                kmin_d = caq_pkg::TRIG_MAX;
              end
            end
            default: ;
          endcase
        end
      end
      caq_pkg::ST_INS_OUT: begin
        if (ofree) begin
          ov_d    = 1'b1;
          okind_d = rsp_kind_q;
          opay_d  = '0;
          odue_d  = rsp_due_q;
          olast_d = 1'b1;
        end
      end
      caq_pkg::ST_SCAN: begin
        // full rotation, nothing removed: count firings, find minimum of survivors
        op_o.shift = 1'b1;
        op_o.write = 1'b1;
        rem_d      = rem_q - CNT_W'(1);
        if (head_due && (nf_q < FW'(caq_pkg::FIRE_LIMIT))) begin
          nf_d = nf_q + FW'(1);
        end else if (head_i.trig < kmin_q) begin
          kmin_d = head_i.trig;
        end
        if (last_step) begin
          if (nf_d == '0) begin
            cycle_d = cyc_inc;
            min_d   = kmin_d;
          end else begin
            rem_d   = count_q;
            fired_d = '0;
          end
        end
      end
      caq_pkg::ST_FIRE: begin
        // second rotation: due entries leave at the head, the rest go to the tail
        if (fire_sel) begin
          if (ofree) begin
            op_o.shift = 1'b1;
            count_d    = cnt_m1;
            fired_d    = fired_q + FW'(1);
            rem_d      = rem_q - CNT_W'(1);
            ov_d       = 1'b1;
            okind_d    = caq_pkg::KIND_FIRED;
            opay_d     = head_i.pay;
            odue_d     = kmin_q;
            olast_d    = (fired_d == nf_q);
          end
        end else begin
          op_o.shift = 1'b1;
          op_o.write = 1'b1;
          rem_d      = rem_q - CNT_W'(1);
        end
        if (step_go && last_step) begin
          cycle_d = cyc_inc;
          min_d   = kmin_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= caq_pkg::ST_IDLE;
      ov_q    <= 1'b0;
      cycle_q <= '0;
      count_q <= '0;
      rem_q   <= '0;
      nf_q    <= '0;
      fired_q <= '0;
      min_q   <= caq_pkg::TRIG_MAX;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      cycle_q <= cycle_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      nf_q    <= nf_d;
      fired_q <= fired_d;
      min_q   <= min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kmin_q     <= kmin_d;
    rsp_kind_q <= rsp_kind_d;
    rsp_due_q  <= rsp_due_d;
    okind_q    <= okind_d;
    opay_q     <= opay_d;
    odue_q     <= odue_d;
    olast_q    <= olast_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {1'b0, odue_q, opay_q};

endmodule

// ===== rtl/cycle_alarm_queue.sv =====
// Cycle alarm queue top level: sequencer plus a row of alarm cells.
// Depends on caq_pkg, caq_cell and caq_ctrl.
//
// A cycle counter with up to MAX_ALARMS pending alarms kept in insertion order in
// a shift chain of cells; only the head cell is read. An insert is accepted, then
// its result goes into the output register. A tick with no alarms pending only
// advances the counter; otherwise one rotation of the chain counts firings and
// finds the earliest surviving trigger, and if something is due a second rotation
// emits and removes the due alarms, one entry past the head per cycle while the
// output register is free. Output back-pressure stalls the insert result and the
// second rotation while an earlier result still waits in the output register. Up
// to 16 alarms fire per tick; the counter saturates at its top.
// The alarm store has no reset; only filled slots are ever read.
module cycle_alarm_queue #(
  parameter int unsigned MAX_ALARMS = caq_pkg::DEF_MAX_ALARMS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [1:0]                     s_axis_tuser,  // [1:0] cmd
  input  logic [caq_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [62:0] when_cycle, [126:63] payload
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [1:0]                     m_axis_tuser,  // [1:0] kind
  output logic                           m_axis_tlast,  // last
  output logic [caq_pkg::OUT_DATA_W-1:0] m_axis_tdata   // [63:0] fired_payload, [126:64] next_due
);

  localparam int unsigned IDX_W = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;

  caq_pkg::chain_op_t op;
  logic [IDX_W-1:0]   wr_pos;
  caq_pkg::entry_t    ent [MAX_ALARMS];

  caq_ctrl #(
    .MAX_ALARMS(MAX_ALARMS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tdata (m_axis_tdata),
    .head_i       (ent[0]),
    .op_o         (op),
    .wr_pos_o     (wr_pos)
  );

  for (genvar i = 0; i < MAX_ALARMS; i++) begin : g_cell
    caq_pkg::entry_t nbr;
    logic            hit;

    // the top cell holds on a shift; its contents are past the fill count anyway
    if (i == MAX_ALARMS - 1) begin : g_top
      assign nbr = ent[i];
    end else begin : g_mid
      assign nbr = ent[i+1];
    end

    assign hit = (wr_pos == IDX_W'(i));

    caq_cell u_cell (
      .clk_i(clk_i),
      .op_i (op),
      .hit_i(hit),
      .nbr_i(nbr),
      .ent_o(ent[i])
    );
  end

endmodule

// ===== tb/cycle_alarm_queue_test.sv =====
// Self-checking testbench for cycle_alarm_queue: directed and random insert/tick items,
// a transaction-level predictor of the alarm list, and random stalls on both stream sides.
// Depends on caq_pkg and the cycle_alarm_queue RTL.
`timescale 1ns / 100ps

module cycle_alarm_queue_test;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [63:0] PAY_MAX     = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] PAY_MIN     = 64'h8000_0000_0000_0000;
  localparam int          STALL_LIMIT = 2000;
  localparam int          DRAIN_WAIT  = 40;
  localparam int          ITEM_COUNT  = 420;

  typedef struct {
    caq_pkg::kind_e             kind;
    logic [caq_pkg::PAY_W-1:0]  pay;
    logic [caq_pkg::TRIG_W-1:0] due;
    logic                       last;
  } alarm_result_t;

  // Tracks the alarm list and counter, and queues the results each item should give.
  class alarm_tracker;
    logic [caq_pkg::TRIG_W-1:0] cycle_now;
    logic [caq_pkg::TRIG_W-1:0] trig_q[$];
    logic [caq_pkg::PAY_W-1:0]  pay_q[$];
    alarm_result_t              pending_results[$];
    int                         errors;

    function new();
      cycle_now = '0;
      errors    = 0;
    endfunction

    function logic [caq_pkg::TRIG_W-1:0] earliest_due();
      logic [caq_pkg::TRIG_W-1:0] best;
      best = caq_pkg::TRIG_MAX;
      foreach (trig_q[i]) if (trig_q[i] < best) best = trig_q[i];
      return best;
    endfunction

    function void note_item(logic [1:0] cmd, logic [caq_pkg::TRIG_W-1:0] when_c,
                            logic [caq_pkg::PAY_W-1:0] pay);
      logic [caq_pkg::TRIG_W:0]   sum;
      logic [caq_pkg::TRIG_W-1:0] trig;
      logic [caq_pkg::TRIG_W-1:0] keep_trig[$];
      logic [caq_pkg::PAY_W-1:0]  keep_pay[$];
      logic [caq_pkg::PAY_W-1:0]  fired[$];
      alarm_result_t              res;
      if (cmd == caq_pkg::CMD_ADD_ABS || cmd == caq_pkg::CMD_ADD_REL) begin
        trig = when_c;
        if (cmd == caq_pkg::CMD_ADD_REL) begin
          sum  = {1'b0, cycle_now} + {1'b0, when_c};
          trig = sum[caq_pkg::TRIG_W] ? caq_pkg::TRIG_MAX : sum[caq_pkg::TRIG_W-1:0];
        end
        if (trig_q.size() < caq_pkg::DEF_MAX_ALARMS) begin
          trig_q   = {trig_q, trig};
          pay_q    = {pay_q, pay};
          res.kind = caq_pkg::KIND_ACCEPT;
        end else begin
          res.kind = caq_pkg::KIND_REJECT;
        end
        res.pay  = '0;
        res.due  = earliest_due();
        res.last = 1'b1;
        pending_results = {pending_results, res};
      end else if (cmd == caq_pkg::CMD_TICK) begin
        foreach (trig_q[i]) begin
          if (trig_q[i] <= cycle_now && fired.size() < caq_pkg::FIRE_LIMIT) begin
            fired = {fired, pay_q[i]};
          end else begin
            keep_trig = {keep_trig, trig_q[i]};
            keep_pay  = {keep_pay, pay_q[i]};
          end
        end
        trig_q = keep_trig;
        pay_q  = keep_pay;
        if (cycle_now != caq_pkg::TRIG_MAX) cycle_now++;
        foreach (fired[k]) begin
          res.kind = caq_pkg::KIND_FIRED;
          res.pay  = fired[k];
          res.due  = earliest_due();
          res.last = (k == fired.size() - 1);
          pending_results = {pending_results, res};
        end
      end
    endfunction

    task report(string what, logic [caq_pkg::PAY_W-1:0] got, logic [caq_pkg::PAY_W-1:0] want);
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [1:0] kind, logic [caq_pkg::PAY_W-1:0] pay,
                      logic [caq_pkg::TRIG_W-1:0] due, logic last);
      alarm_result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result kind", 64'(kind), '0);
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind) report("kind", 64'(kind), 64'(want.kind));
        if (pay !== want.pay) report("fired_payload", pay, want.pay);
        if (due !== want.due) report("next_due", 64'(due), 64'(want.due));
        if (last !== want.last) report("last", 64'(last), 64'(want.last));
      end
    endtask
  endclass

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [1:0]                     s_axis_tuser  = '0;
  logic [caq_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [1:0]                     m_axis_tuser;
  logic                           m_axis_tlast;
  logic [caq_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  alarm_tracker tracker = new();
  bit           quiet_sides = 1'b0;  // both sides run without gaps while set
  int           items_sent  = 0;
  int           stall_cycles = 0;

  cycle_alarm_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [caq_pkg::PAY_W-1:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  // tvalid stays high across back-to-back items; it is only lowered for a gap.
  task automatic send_item(logic [1:0] cmd, logic [caq_pkg::TRIG_W-1:0] when_c,
                           logic [caq_pkg::PAY_W-1:0] pay);
    int gap;
    gap = quiet_sides ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, pay, when_c};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    tracker.note_item(cmd, when_c, pay);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic tick();
    send_item(caq_pkg::CMD_TICK, caq_pkg::TRIG_W'({$urandom, $urandom}), rand_payload());
  endtask

  // Alarm the given distance ahead of the counter, relative or absolute; absolute ones are sometimes already past.
  task automatic add_near(int unsigned ahead);
    logic [caq_pkg::TRIG_W-1:0] at;
    if ($urandom_range(0, 1)) begin
      send_item(caq_pkg::CMD_ADD_REL, caq_pkg::TRIG_W'(ahead), rand_payload());
    end else begin
      at = tracker.cycle_now + caq_pkg::TRIG_W'(ahead);
      if ($urandom_range(0, 4) == 0 && tracker.cycle_now > 3)
        at = tracker.cycle_now - caq_pkg::TRIG_W'($urandom_range(1, 3));
      send_item(caq_pkg::CMD_ADD_ABS, at, rand_payload());
    end
  endtask

  // Result side: random stall per item, check at each handshake.
  initial begin
    int gap;
    forever begin
      gap = quiet_sides ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      tracker.check_result(m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[126:64],
                           m_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty tick, field extremes, saturating relative add, unused command.
    tick();
    send_item(caq_pkg::CMD_ADD_ABS, '0, PAY_MAX);
    send_item(caq_pkg::CMD_ADD_ABS, caq_pkg::TRIG_MAX, PAY_MIN);
    send_item(caq_pkg::CMD_ADD_REL, caq_pkg::TRIG_MAX, '1);
    send_item(caq_pkg::CMD_ADD_REL, '0, 64'h5555_5555_5555_5555);
    send_item(CMD_UNUSED, caq_pkg::TRIG_W'({$urandom, $urandom}), rand_payload());
    tick();  // two alarms fire in insertion order
    tick();  // only far alarms left: quiet tick
    // Fill the list, then one insert past capacity.
    for (int i = 0; i < caq_pkg::DEF_MAX_ALARMS - 2; i++)
      send_item((i % 2) ? caq_pkg::CMD_ADD_REL : caq_pkg::CMD_ADD_ABS,
                caq_pkg::TRIG_W'(i), rand_payload());
    send_item(caq_pkg::CMD_ADD_ABS, '0, 64'haaaa_aaaa_aaaa_aaaa);
    tick();
    tick();

    // Random: mostly insert bursts followed by ticks, some noise.
    while (items_sent < ITEM_COUNT) begin
      quiet_sides = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          repeat ($urandom_range(1, 16)) add_near($urandom_range(0, 6));
          repeat ($urandom_range(1, 8)) tick();
        end
        6: begin
          repeat (caq_pkg::DEF_MAX_ALARMS) add_near(0);
          repeat (2) tick();
        end
        7: repeat ($urandom_range(1, 10)) tick();
        default: begin
          send_item(CMD_UNUSED, caq_pkg::TRIG_W'({$urandom, $urandom}), rand_payload());
          add_near($urandom_range(0, 40));
        end
      endcase
    end
    quiet_sides = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (tracker.pending_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (tracker.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
